// ===== rtl/core/phr_pkg.sv =====
`default_nettype none
package phr_pkg;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_REC_WR,
    ST_REC_RD1,
    ST_REC_CHK,
    ST_Q_RD,
    ST_Q_CHK,
    ST_Q_RDN,
    ST_Q_DIV,
    ST_Q_MUL,
    ST_Q_OUT
  } state_t;

  typedef struct packed {
    logic load_in;
    logic rec_write;
    logic rec_rd1;
    logic rec_prune;
    logic q_init;
    logic q_rd;
    logic q_take;
    logic q_rdn;
    logic div_start;
    logic mul_start;
    logic res_load;
  } cmd_t;

  typedef struct packed {
    logic is_query;
    logic q_trivial;
    logic prune;
    logic older;
    logic walk_done;
    logic do_lerp;
    logic div_done;
    logic mul_done;
  } sts_t;

  localparam int unsigned FRAC_BITS = 16;
  localparam logic [23:0] MAX_AGE_RESET = 24'd1000000;
  localparam logic OP_RECORD = 1'b0;

endpackage
`default_nettype wire

// ===== rtl/core/position_history_rewind_unit.sv =====
// Position history with rewind queries.
// Input channel (in_valid/in_ready) carries record (in_op=0) or query (in_op=1).
// A record stores time, position and teleport flag in a 64-entry ring and may
// drop the oldest entry once the next entry ages past max_age; it yields no
// result. A query walks the ring newest to oldest, reading then checking each
// entry through the single RAM read port, then for an interpolated answer runs
// a restoring divide (17 quotient bits) for the Q1.16 fraction and then the
// multiply, one axis a cycle. An empty store or zero look-back skips the walk
// and answers with the input position. The next item is taken in the cycle
// after the result is stored; one item is in flight at a time.
// Results leave through out_valid/out_ready and wait in a register while the
// receiver stalls; the block takes no new item until the result is stored.
// cfg_valid/cfg_ready writes max_age (always ready).
// Synchronous reset empties the history and sets max_age to 1000000 us; the
// ring contents need no clearing since only occupied slots are read.
`default_nettype none
module position_history_rewind_unit #(
  parameter int unsigned HISTORY_DEPTH = 64
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [23:0]        cfg_max_age,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               in_op,
  input  wire logic [31:0]        in_now_time,
  input  wire logic signed [31:0] in_pos_x,
  input  wire logic signed [31:0] in_pos_y,
  input  wire logic signed [31:0] in_pos_z,
  input  wire logic               in_teleported,
  input  wire logic [23:0]        in_lookback,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [31:0]      out_rewound_x,
  output logic signed [31:0]      out_rewound_y,
  output logic signed [31:0]      out_rewound_z,
  output logic                    out_from_history
);
  phr_pkg::cmd_t cmd;
  phr_pkg::sts_t sts;
  logic [$clog2(HISTORY_DEPTH):0] count;

  assign cfg_ready = 1'b1;

  phr_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .sts(sts), .cmd(cmd)
  );

  phr_dp #(.DEPTH(HISTORY_DEPTH)) u_dp (
    .clk(clk), .rst_n(rst_n), .cfg_valid(cfg_valid), .cfg_max_age(cfg_max_age),
    .in_op(in_op), .in_now_time(in_now_time), .in_pos_x(in_pos_x),
    .in_pos_y(in_pos_y), .in_pos_z(in_pos_z), .in_teleported(in_teleported),
    .in_lookback(in_lookback), .cmd(cmd), .sts(sts),
    .out_rewound_x(out_rewound_x), .out_rewound_y(out_rewound_y),
    .out_rewound_z(out_rewound_z), .out_from_history(out_from_history),
    .count(count)
  );

  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    count <= ($clog2(HISTORY_DEPTH)+1)'(HISTORY_DEPTH)) else $error("count overflow");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
  a_prune_rec: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rec_prune |-> $past(cmd.rec_rd1)) else $error("prune out of order");
endmodule
`default_nettype wire

// ===== rtl/core/phr_ram.sv =====
`default_nettype none
module phr_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== rtl/core/phr_ctrl.sv =====
`default_nettype none
module phr_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  wire logic          out_ready,
  input  wire phr_pkg::sts_t sts,
  output phr_pkg::cmd_t      cmd
);
  phr_pkg::state_t state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= phr_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == phr_pkg::ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      phr_pkg::ST_IDLE:    if (in_valid) state_nxt = sts.is_query ? phr_pkg::ST_Q_RD
                                                                  : phr_pkg::ST_REC_WR;
      phr_pkg::ST_REC_WR:  state_nxt = phr_pkg::ST_REC_RD1;
      phr_pkg::ST_REC_RD1: state_nxt = phr_pkg::ST_REC_CHK;
      phr_pkg::ST_REC_CHK: state_nxt = phr_pkg::ST_IDLE;
      phr_pkg::ST_Q_RD:    state_nxt = sts.q_trivial ? phr_pkg::ST_Q_OUT : phr_pkg::ST_Q_CHK;
      phr_pkg::ST_Q_CHK: begin
        if (sts.older || sts.walk_done)
          state_nxt = sts.do_lerp ? phr_pkg::ST_Q_RDN : phr_pkg::ST_Q_OUT;
        else
          state_nxt = phr_pkg::ST_Q_RD;
      end
      phr_pkg::ST_Q_RDN:   state_nxt = phr_pkg::ST_Q_DIV;
      phr_pkg::ST_Q_DIV:   if (sts.div_done) state_nxt = phr_pkg::ST_Q_MUL;
      phr_pkg::ST_Q_MUL:   if (sts.mul_done) state_nxt = phr_pkg::ST_Q_OUT;
      phr_pkg::ST_Q_OUT:   if (!out_valid_r || out_ready) state_nxt = phr_pkg::ST_IDLE;
      default:             state_nxt = phr_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      phr_pkg::ST_IDLE: begin
        cmd.load_in = in_valid;
        cmd.q_init  = in_valid && sts.is_query;
      end
      phr_pkg::ST_REC_WR:  cmd.rec_write = 1'b1;
      phr_pkg::ST_REC_RD1: cmd.rec_rd1 = 1'b1;
      phr_pkg::ST_REC_CHK: cmd.rec_prune = sts.prune;
      phr_pkg::ST_Q_RD:    cmd.q_rd = 1'b1;
      phr_pkg::ST_Q_CHK: begin
        cmd.q_take = (sts.older || sts.walk_done) && !sts.do_lerp;
        cmd.q_rdn  = (sts.older || sts.walk_done) && sts.do_lerp;
      end
      phr_pkg::ST_Q_RDN:   cmd.div_start = 1'b1;
      phr_pkg::ST_Q_DIV:   cmd.mul_start = sts.div_done;
      phr_pkg::ST_Q_OUT: begin
        if (!out_valid_r || out_ready) begin
          cmd.res_load  = 1'b1;
          out_valid_nxt = 1'b1;
        end
      end
      default: ;
    endcase
  end
endmodule
`default_nettype wire

// ===== rtl/core/phr_dp.sv =====
`default_nettype none
module phr_dp #(
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_valid,
  input  wire logic [23:0]          cfg_max_age,
  input  wire logic                 in_op,
  input  wire logic [31:0]          in_now_time,
  input  wire logic signed [31:0]   in_pos_x,
  input  wire logic signed [31:0]   in_pos_y,
  input  wire logic signed [31:0]   in_pos_z,
  input  wire logic                 in_teleported,
  input  wire logic [23:0]          in_lookback,
  input  wire phr_pkg::cmd_t        cmd,
  output phr_pkg::sts_t             sts,
  output logic signed [31:0]        out_rewound_x,
  output logic signed [31:0]        out_rewound_y,
  output logic signed [31:0]        out_rewound_z,
  output logic                      out_from_history,
  output logic [$clog2(DEPTH):0]    count
);
  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned EW = 32 * 4 + 1;
  localparam logic [AW:0] DEPTH_C = (AW + 1)'(DEPTH);
  localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);

  logic [23:0] max_age_r;
  logic [AW-1:0] oldest_r;
  logic [AW:0] count_r;
  logic [31:0] now_r;
  logic signed [31:0] px_r, py_r, pz_r;
  logic tp_r;
  logic [23:0] lb_r;
  logic [AW:0] k_r;
  logic [AW:0] wsum;
  logic [AW-1:0] wslot;
  logic [AW-1:0] waddr;

  logic ram_we;
  logic [AW-1:0] raddr;
  logic [EW-1:0] rdata;
  logic [31:0] rt;
  logic signed [31:0] rx, ry, rz;
  logic rtp;

  logic signed [32:0] target_r;
  logic [31:0] ti_r;
  logic signed [31:0] xi_r, yi_r, zi_r;
  logic [31:0] dnum_r, dden_r;
  logic [16:0] frac_r;
  logic [4:0] cnt_r;
  logic div_busy_r, div_done_r;
  logic eq_r;
  logic [1:0] ax_r;
  logic mul_busy_r, mul_done_r;
  logic signed [31:0] ox_r, oy_r, oz_r;
  logic signed [31:0] lx_r, ly_r, lz_r;
  logic [AW:0] kp1;
  logic [AW:0] rd_off;
  logic [AW:0] sum_k;
  logic signed [32:0] limit;

  assign count = count_r;
  assign ram_we = cmd.rec_write;
  assign kp1 = k_r + 1'b1;

  always_comb begin
    wsum = {1'b0, oldest_r} + count_r;
    wslot = (wsum >= DEPTH_C) ? AW'(wsum - DEPTH_C) : wsum[AW-1:0];
    waddr = (count_r == DEPTH_C) ? oldest_r : wslot;
  end

  // the walk reads entry k_r-1 while k_r steps down, so the check sees entry k_r
  always_comb begin
    if (cmd.q_rdn) rd_off = kp1;
    else if (cmd.rec_rd1) rd_off = (AW + 1)'(1);
    else if (cmd.q_rd) rd_off = k_r - 1'b1;
    else rd_off = k_r;
    sum_k = {1'b0, oldest_r} + rd_off;
    if (sum_k >= DEPTH_C) sum_k = sum_k - DEPTH_C;
    raddr = sum_k[AW-1:0];
  end

  phr_ram #(.WIDTH(EW), .DEPTH(DEPTH)) u_ram (
    .clk(clk), .we(ram_we),
    .waddr(waddr),
    .wdata({now_r, px_r, py_r, pz_r, tp_r}),
    .raddr(raddr), .rdata(rdata)
  );
  assign {rt, rx, ry, rz, rtp} = rdata;

  assign limit = $signed({1'b0, now_r}) - $signed({9'd0, max_age_r});

  assign sts.is_query  = (in_op != phr_pkg::OP_RECORD);
  assign sts.q_trivial = (lb_r == '0) || (count_r == '0);
  assign sts.prune     = (count_r > (AW + 1)'(1)) && ($signed({1'b0, rt}) < limit);
  assign sts.older     = $signed({1'b0, rt}) < target_r;
  assign sts.walk_done = (k_r == '0);
  assign sts.do_lerp   = sts.older && !rtp && (kp1 < count_r);
  assign sts.div_done  = div_done_r;
  assign sts.mul_done  = mul_done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_age_r <= phr_pkg::MAX_AGE_RESET;
      oldest_r  <= '0;
      count_r   <= '0;
    end else begin
      if (cfg_valid) max_age_r <= cfg_max_age;
      if (cmd.rec_write) begin
        if (count_r == DEPTH_C) oldest_r <= (oldest_r == LAST_SLOT) ? '0 : oldest_r + 1'b1;
        else count_r <= count_r + 1'b1;
      end
      if (cmd.rec_prune) begin
        oldest_r <= (oldest_r == LAST_SLOT) ? '0 : oldest_r + 1'b1;
        count_r  <= count_r - 1'b1;
      end
    end
  end

  // Quotient is one restoring bit a cycle: the first step gives the integer
  // bit, the next sixteen the fraction. Multiply uses one axis a cycle.
  logic [32:0] rem_sh;
  logic signed [31:0] pa, pb;
  logic signed [32:0] diff;
  logic signed [50:0] prod;
  always_comb begin
    rem_sh = (cnt_r == '0) ? {1'b0, dnum_r} : {dnum_r, 1'b0};
    case (ax_r)
      2'd0:    begin pa = xi_r; pb = ox_r; end
      2'd1:    begin pa = yi_r; pb = oy_r; end
      default: begin pa = zi_r; pb = oz_r; end
    endcase
    diff = 33'(pb) - 33'(pa);
    prod = 51'(diff) * $signed({34'd0, frac_r}) + 51'sd32768;
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      now_r <= in_now_time; px_r <= in_pos_x; py_r <= in_pos_y; pz_r <= in_pos_z;
      tp_r <= in_teleported; lb_r <= in_lookback;
      target_r <= $signed({1'b0, in_now_time}) - $signed({9'd0, in_lookback});
    end
    if (cmd.q_init) k_r <= count_r;
    if (cmd.q_rd) k_r <= k_r - 1'b1;
    if (cmd.q_rdn) begin
      ti_r <= rt; xi_r <= rx; yi_r <= ry; zi_r <= rz;
    end
    // found entry with no interpolation: latch as answer
    if (cmd.q_take) begin
      lx_r <= rx; ly_r <= ry; lz_r <= rz;
    end
    if (cmd.div_start) begin
      ox_r <= rx; oy_r <= ry; oz_r <= rz;
      if (rt == ti_r) begin
        lx_r <= rx; ly_r <= ry; lz_r <= rz;
      end
      dnum_r <= 32'(target_r - $signed({1'b0, ti_r}));
      dden_r <= rt - ti_r;
      frac_r <= '0;
      cnt_r <= '0;
      eq_r <= (rt == ti_r);
    end else if (div_busy_r) begin
      if (rem_sh >= {1'b0, dden_r}) begin
        dnum_r <= 32'(rem_sh - {1'b0, dden_r});
        frac_r <= {frac_r[15:0], 1'b1};
      end else begin
        dnum_r <= rem_sh[31:0];
        frac_r <= {frac_r[15:0], 1'b0};
      end
      cnt_r <= cnt_r + 1'b1;
    end
    if (cmd.mul_start) begin
      ax_r <= '0;
    end else if (mul_busy_r) begin
      case (ax_r)
        2'd0:    lx_r <= 32'(pa + 32'(prod >>> phr_pkg::FRAC_BITS));
        2'd1:    ly_r <= 32'(pa + 32'(prod >>> phr_pkg::FRAC_BITS));
        default: lz_r <= 32'(pa + 32'(prod >>> phr_pkg::FRAC_BITS));
      endcase
      ax_r <= ax_r + 1'b1;
    end
    if (cmd.res_load) begin
      if (sts.q_trivial) begin
        out_rewound_x <= px_r; out_rewound_y <= py_r; out_rewound_z <= pz_r;
      end else begin
        out_rewound_x <= lx_r; out_rewound_y <= ly_r; out_rewound_z <= lz_r;
      end
      out_from_history <= !sts.q_trivial;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_busy_r <= 1'b0;
      div_done_r <= 1'b0;
      mul_busy_r <= 1'b0;
      mul_done_r <= 1'b0;
    end else begin
      if (cmd.div_start) begin
        div_busy_r <= (rt != ti_r);
        div_done_r <= (rt == ti_r);
      end else if (div_busy_r) begin
        if (cnt_r == 5'd16) begin
          div_busy_r <= 1'b0;
          div_done_r <= 1'b1;
        end
      end else begin
        div_done_r <= 1'b0;
      end
      if (cmd.mul_start) begin
        mul_busy_r <= !eq_r;
        mul_done_r <= eq_r;
      end else if (mul_busy_r) begin
        if (ax_r == 2'd2) begin
          mul_busy_r <= 1'b0;
          mul_done_r <= 1'b1;
        end
      end else begin
        mul_done_r <= 1'b0;
      end
    end
  end
endmodule
`default_nettype wire

// ===== tb/sv/phr_history_checker.sv =====
`timescale 1ns / 1ps
module phr_history_checker (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_valid,
  input  wire logic               cfg_ready,
  input  wire logic [23:0]        cfg_max_age,
  input  wire logic               in_valid,
  input  wire logic               in_ready,
  input  wire logic               in_op,
  input  wire logic [31:0]        in_now_time,
  input  wire logic signed [31:0] in_pos_x,
  input  wire logic signed [31:0] in_pos_y,
  input  wire logic signed [31:0] in_pos_z,
  input  wire logic               in_teleported,
  input  wire logic [23:0]        in_lookback,
  input  wire logic               out_valid,
  input  wire logic               out_ready,
  input  wire logic signed [31:0] out_rewound_x,
  input  wire logic signed [31:0] out_rewound_y,
  input  wire logic signed [31:0] out_rewound_z,
  input  wire logic               out_from_history,
  output int                      fail_count,
  output int                      rewinds_pending
);
  localparam int DEPTH = 64;

  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic               hist;
  } rewind_t;

  logic [31:0]        hist_time [DEPTH];
  logic signed [31:0] hist_x [DEPTH];
  logic signed [31:0] hist_y [DEPTH];
  logic signed [31:0] hist_z [DEPTH];
  logic               hist_tp [DEPTH];
  int                 head;
  int                 fill;
  logic [23:0]        age_limit;
  rewind_t            rewinds_due[$];

  function automatic int ring(int k);
    return (head + k) % DEPTH;
  endfunction

  function automatic logic signed [31:0] blend(logic signed [31:0] a, logic signed [31:0] b,
                                               logic [16:0] frac);
    logic signed [63:0] d;
    logic signed [63:0] p;
    logic signed [63:0] f;
    d = b;
    d = d - a;
    f = {47'b0, frac};
    p = d * f + 64'sd32768;
    p = a + (p >>> 16);
    return p[31:0];
  endfunction

  task automatic store_position();
    int s;
    logic signed [63:0] lim;
    logic signed [63:0] t1;
    if (fill >= DEPTH) begin
      s = head;
      head = (head + 1) % DEPTH;
    end else begin
      s = ring(fill);
      fill++;
    end
    hist_time[s] = in_now_time;
    hist_x[s] = in_pos_x;
    hist_y[s] = in_pos_y;
    hist_z[s] = in_pos_z;
    hist_tp[s] = in_teleported;
    if (fill > 1) begin
      lim = {32'b0, in_now_time};
      lim = lim - {40'b0, age_limit};
      t1 = {32'b0, hist_time[ring(1)]};
      // drop the oldest once the next one has aged out
      if (t1 < lim) begin
        head = (head + 1) % DEPTH;
        fill--;
      end
    end
  endtask

  function automatic rewind_t rewind_position();
    rewind_t r;
    logic signed [63:0] target;
    logic signed [63:0] ts;
    logic signed [63:0] tn;
    logic [63:0] frac;
    int k;
    int s;
    int n;
    bit found;
    r.x = in_pos_x;
    r.y = in_pos_y;
    r.z = in_pos_z;
    r.hist = 1'b0;
    if (in_lookback != 0 && fill != 0) begin
      target = {32'b0, in_now_time};
      target = target - {40'b0, in_lookback};
      r.hist = 1'b1;
      found = 0;
      s = ring(0);
      for (k = fill - 1; k >= 0; k--) begin
        s = ring(k);
        ts = {32'b0, hist_time[s]};
        if (ts < target) begin
          found = 1;
          break;
        end
      end
      if (!found) s = ring(0);
      r.x = hist_x[s];
      r.y = hist_y[s];
      r.z = hist_z[s];
      if (found && !hist_tp[s] && k + 1 < fill) begin
        n = ring(k + 1);
        ts = {32'b0, hist_time[s]};
        tn = {32'b0, hist_time[n]};
        if (tn == ts) begin
          r.x = hist_x[n];
          r.y = hist_y[n];
          r.z = hist_z[n];
        end else begin
          frac = ((target - ts) * 64'sd65536) / (tn - ts);
          if (frac > 64'd65536) frac = 64'd65536;
          r.x = blend(hist_x[s], hist_x[n], frac[16:0]);
          r.y = blend(hist_y[s], hist_y[n], frac[16:0]);
          r.z = blend(hist_z[s], hist_z[n], frac[16:0]);
        end
      end
    end
    return r;
  endfunction

  assign rewinds_pending = rewinds_due.size();

  always @(posedge clk) begin
    rewind_t e;
    if (!rst_n) begin
      head = 0;
      fill = 0;
      age_limit = phr_pkg::MAX_AGE_RESET;
      rewinds_due.delete();
      fail_count = 0;
    end else begin
      if (cfg_valid && cfg_ready) age_limit = cfg_max_age;
      if (in_valid && in_ready) begin
        if (in_op == phr_pkg::OP_RECORD) store_position();
        else rewinds_due.push_back(rewind_position());
      end
      if (out_valid && out_ready) begin
        if (rewinds_due.size() == 0) begin
          $display("%0t: unexpected result x=%h y=%h z=%h hist=%b", $time,
                   out_rewound_x, out_rewound_y, out_rewound_z, out_from_history);
          fail_count++;
        end else begin
          e = rewinds_due.pop_front();
          if (out_rewound_x !== e.x || out_rewound_y !== e.y || out_rewound_z !== e.z ||
              out_from_history !== e.hist) begin
            $display("%0t: mismatch expected x=%h y=%h z=%h hist=%b actual x=%h y=%h z=%h hist=%b",
                     $time, e.x, e.y, e.z, e.hist, out_rewound_x, out_rewound_y,
                     out_rewound_z, out_from_history);
            fail_count++;
          end
        end
      end
    end
  end
endmodule

// ===== tb/sv/tb_position_history_rewind_unit.sv =====
`timescale 1ns / 1ps
module tb_position_history_rewind_unit;
  localparam logic OP_QUERY = ~phr_pkg::OP_RECORD;
  localparam int   CYCLE_LIMIT = 4000000;
  localparam int   DRAIN_CYCLES = 200;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [23:0]        cfg_max_age = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               in_op = 1'b0;
  logic [31:0]        in_now_time = '0;
  logic signed [31:0] in_pos_x = '0;
  logic signed [31:0] in_pos_y = '0;
  logic signed [31:0] in_pos_z = '0;
  logic               in_teleported = 1'b0;
  logic [23:0]        in_lookback = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [31:0] out_rewound_x;
  logic signed [31:0] out_rewound_y;
  logic signed [31:0] out_rewound_z;
  logic               out_from_history;
  int                 fail_count;
  int                 rewinds_pending;

  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          hold_reqs = 0;
  int          holds_done = 0;
  int          hold_left = 0;
  int          cycles = 0;
  logic [31:0] clock_us = 32'd5000;
  logic signed [31:0] walk_x = '0, walk_y = '0, walk_z = '0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  position_history_rewind_unit dut (.*);

  phr_history_checker chk (.*);

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // receiver: random stalls, plus a long hold-off on request
  always @(negedge clk) begin
    if (!rst_n) out_ready <= 1'b0;
    else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (holds_done < hold_reqs) begin
      holds_done <= holds_done + 1;
      hold_left <= 400;
      out_ready <= 1'b0;
    end else out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // called and returns at a falling edge
  task automatic send(logic op, logic [31:0] now, logic signed [31:0] x,
                      logic signed [31:0] y, logic signed [31:0] z,
                      logic tp, logic [23:0] lb);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_op <= op;
    in_now_time <= now;
    in_pos_x <= x;
    in_pos_y <= y;
    in_pos_z <= z;
    in_teleported <= tp;
    in_lookback <= lb;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic settle_and_write(logic [23:0] age);
    in_valid <= 1'b0;
    while (rewinds_pending != 0) @(negedge clk);
    // a record leaves no result, so let any in-flight work finish
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_max_age <= age;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_item();
    logic signed [31:0] step;
    if ($urandom_range(99) < 80) begin
      if ($urandom_range(99) < 70) begin
        clock_us = clock_us + (($urandom_range(9) == 0) ? 0 : $urandom_range(40000));
        if ($urandom_range(9) == 0) begin
          walk_x = $urandom;
          walk_y = $urandom;
          walk_z = $urandom;
        end else begin
          step = $urandom_range(8191); walk_x = walk_x + step - 4096;
          step = $urandom_range(8191); walk_y = walk_y + step - 4096;
          step = $urandom_range(8191); walk_z = walk_z + step - 4096;
        end
        send(phr_pkg::OP_RECORD, clock_us, walk_x, walk_y, walk_z, $urandom_range(9) == 0,
             24'($urandom));
      end else begin
        send(OP_QUERY, clock_us + $urandom_range(20000), walk_x, walk_y, walk_z,
             1'($urandom),
             24'(($urandom_range(9) == 0) ? $urandom : $urandom_range(400000)));
      end
    end else begin
      send(1'($urandom), $urandom, $urandom, $urandom, $urandom, 1'($urandom),
           24'($urandom));
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // empty store and zero look-back
    send(OP_QUERY, 32'd100, 32'sh7fffffff, 32'sh80000000, 32'sd1, 1'b0, 24'd50);
    send(phr_pkg::OP_RECORD, 32'd0, 32'sh80000000, 32'sh7fffffff, -32'sd1, 1'b0, 24'hffffff);
    send(OP_QUERY, 32'd10, 32'sd5, 32'sd6, 32'sd7, 1'b1, 24'd0);
    send(phr_pkg::OP_RECORD, 32'd1000, 32'sh7fffffff, 32'sh80000000, 32'sd256, 1'b0, 24'd0);
    // interpolate across the full range, ties and halfway
    send(OP_QUERY, 32'd1500, '0, '0, '0, 1'b0, 24'd1000);
    send(OP_QUERY, 32'd1500, '0, '0, '0, 1'b0, 24'd999);
    send(OP_QUERY, 32'd1999, '0, '0, '0, 1'b0, 24'd1000);
    // newest entry found
    send(OP_QUERY, 32'd5000, '0, '0, '0, 1'b0, 24'd1);
    // early target between two entries, and a negative target with no entry older
    send(OP_QUERY, 32'd500, '0, '0, '0, 1'b0, 24'd400);
    send(OP_QUERY, 32'd10, '0, '0, '0, 1'b0, 24'hffffff);
    // teleport and equal times
    send(phr_pkg::OP_RECORD, 32'd2000, 32'sd100, 32'sd200, 32'sd300, 1'b1, 24'd0);
    send(phr_pkg::OP_RECORD, 32'd3000, 32'sd900, 32'sd800, 32'sd700, 1'b0, 24'd0);
    send(OP_QUERY, 32'd2500, '0, '0, '0, 1'b0, 24'd1);
    send(phr_pkg::OP_RECORD, 32'd3000, 32'sd11, 32'sd22, 32'sd33, 1'b0, 24'd0);
    send(phr_pkg::OP_RECORD, 32'd4000, 32'sd44, 32'sd55, 32'sd66, 1'b0, 24'd0);
    send(OP_QUERY, 32'd3500, '0, '0, '0, 1'b0, 24'd499);
    // time extremes, and a prune far past the default age
    send(phr_pkg::OP_RECORD, 32'hffffffff, -32'sd5, 32'sd5, '0, 1'b0, 24'd0);
    send(OP_QUERY, 32'hffffffff, '0, '0, '0, 1'b0, 24'hffffff);
    send(OP_QUERY, 32'hffffffff, '0, '0, '0, 1'b0, 24'd1);

    settle_and_write(24'd0);
    for (int i = 0; i < 80; i++) random_item();

    settle_and_write(24'hffffff);
    // long receiver hold-off with the sender still offering
    hold_reqs = hold_reqs + 1;
    for (int i = 0; i < 170; i++) random_item();

    send_idle_pct = 82;
    settle_and_write(24'd30000);
    for (int i = 0; i < 120; i++) random_item();

    send_idle_pct = 0;
    recv_stall_pct = 82;
    settle_and_write(24'd1000000);
    for (int i = 0; i < 120; i++) random_item();

    send_idle_pct = 35;
    recv_stall_pct = 35;
    settle_and_write(24'($urandom));
    for (int i = 0; i < 120; i++) random_item();

    in_valid <= 1'b0;
    while (rewinds_pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
